// File: rtl/core/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg
// Shared constants and register indexes of the triangle plane slicer.
// ----------------------------------------------------------------------------
package tps_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int RATIO_BITS      = 30;
    localparam int DIV_STAGES      = RATIO_BITS + 1;
    localparam int MUL_STAGES      = 3;
    localparam int CFG_IDX_W       = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_DISTANCE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE      = 3'd4;

    typedef logic [2:0][31:0]      t_vec;
    typedef logic [2:0][2:0][31:0] t_tri;

endpackage

// File: rtl/core/triangle_plane_slice_top.sv
// ----------------------------------------------------------------------------
// triangle_plane_slice_top: cuts one triangle with the plane n.x = d.
// Throughput is one triangle per cycle while i_stall does not hold the output; the 31-stage ratio dividers set depth.
// Synchronous active-low reset clears the pipeline valid bits and loads the default plane.
// ----------------------------------------------------------------------------
module triangle_plane_slice_top #(
    parameter int COORD_FRAC_BITS = tps_pkg::COORD_FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [31:0]             i_ax,
    input  logic signed [31:0]             i_ay,
    input  logic signed [31:0]             i_az,
    input  logic signed [31:0]             i_bx,
    input  logic signed [31:0]             i_by,
    input  logic signed [31:0]             i_bz,
    input  logic signed [31:0]             i_cx,
    input  logic signed [31:0]             i_cy,
    input  logic signed [31:0]             i_cz,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_hit,
    output logic signed [31:0]             o_start_x,
    output logic signed [31:0]             o_start_y,
    output logic signed [31:0]             o_start_z,
    output logic signed [31:0]             o_end_x,
    output logic signed [31:0]             o_end_y,
    output logic signed [31:0]             o_end_z,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);

    typedef struct packed {
        tps_pkg::t_tri vtx;
        logic [2:0]    ok;
        logic [63:0]   dab;
        logic [63:0]   dbc;
    } t_side_div;

    typedef struct packed {
        tps_pkg::t_vec p0;
        tps_pkg::t_vec p1;
        logic          hit;
        logic [63:0]   dab;
        logic [63:0]   dbc;
    } t_side_dot;

    typedef struct packed {
        tps_pkg::t_vec p0;
        tps_pkg::t_vec p1;
        logic          hit;
    } t_side_fin;

    function automatic logic [127:0] norm_step(input logic [127:0] td, input int k);
        logic [63:0] t, d;
        begin
            t = td[127:64];
            d = td[63:0];
            if ((d >> (31 + k)) != 64'd0) begin
                t = t >> k;
                d = d >> k;
            end
            return {t, d};
        end
    endfunction

    function automatic logic same_point(input tps_pkg::t_vec a, input tps_pkg::t_vec b,
                                        input logic [15:0] tol);
        logic signed [33:0] d, t;
        logic r;
        begin
            r = 1'b1;
            t = $signed({18'd0, tol});
            for (int j = 0; j < 3; j++) begin
                d = 34'($signed(a[j])) - 34'($signed(b[j]));
                if (!(d < t && d > -t)) r = 1'b0;
            end
            return r;
        end
    endfunction

    // Configuration registers.
    logic signed [31:0] r_nx, r_ny, r_nz, r_d;
    logic [15:0]        r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nx  <= '0;
            r_ny  <= '0;
            r_nz  <= 32'(64'd1 << COORD_FRAC_BITS);
            r_d   <= '0;
            r_tol <= 16'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tps_pkg::CFG_NORMAL_X:       r_nx  <= i_cfg_data;
                tps_pkg::CFG_NORMAL_Y:       r_ny  <= i_cfg_data;
                tps_pkg::CFG_NORMAL_Z:       r_nz  <= i_cfg_data;
                tps_pkg::CFG_PLANE_DISTANCE: r_d   <= i_cfg_data;
                tps_pkg::CFG_TOLERANCE:      r_tol <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    logic w_en, w_acc;
    logic r_out_valid;

    assign w_en    = !(r_out_valid && i_stall);
    assign o_stall = !w_en;
    assign w_acc   = i_valid && w_en;

    // Stage 1: projection products.
    tps_pkg::t_tri w_vtx;
    tps_pkg::t_vec w_nrm;
    logic signed [63:0] n_prod [3][3];
    logic signed [63:0] r1_prod [3][3];
    tps_pkg::t_tri r1_vtx;
    logic r_v1;

    assign w_vtx = {{i_cz, i_cy, i_cx}, {i_bz, i_by, i_bx}, {i_az, i_ay, i_ax}};
    assign w_nrm = {r_nz, r_ny, r_nx};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_prod[i][j] = $signed(w_vtx[i][j]) * $signed(w_nrm[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_vtx  <= w_vtx;
            r1_prod <= n_prod;
        end
    end

    // Stage 2: projected vertices.
    logic signed [63:0] n_pr [3];
    logic signed [63:0] r2_pr [3];
    tps_pkg::t_tri r2_vtx;
    logic r_v2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_pr[i] = (r1_prod[i][0] >>> COORD_FRAC_BITS)
                    + (r1_prod[i][1] >>> COORD_FRAC_BITS)
                    + (r1_prod[i][2] >>> COORD_FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_vtx <= r1_vtx;
            r2_pr  <= n_pr;
        end
    end

    // Stage 3: edge terms and acceptance tests.
    logic signed [63:0] n_t [3];
    logic signed [63:0] n_den [3];
    logic [2:0]         n_ok;
    logic [63:0]        r3_ut [3];
    logic [63:0]        r3_ud [3];
    logic [2:0]         r3_ok;
    logic [63:0]        r3_dab, r3_dbc;
    tps_pkg::t_tri      r3_vtx;
    logic r_v3;

    always_comb begin
        int k;
        for (int i = 0; i < 3; i++) begin
            k = (i == 2) ? 0 : i + 1;
            n_t[i]   = r_d - r2_pr[i];
            n_den[i] = r2_pr[k] - r2_pr[i];
            if (n_den[i] < 0) begin
                n_t[i]   = -n_t[i];
                n_den[i] = -n_den[i];
            end
            n_ok[i] = (n_den[i] != 0) && (n_den[i] >= $signed({48'd0, r_tol}))
                    && (n_t[i] >= 0) && (n_t[i] <= n_den[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_vtx <= r2_vtx;
            r3_ok  <= n_ok;
            r3_dab <= 64'(r2_pr[1] - r2_pr[0]);
            r3_dbc <= 64'(r2_pr[2] - r2_pr[1]);
            for (int i = 0; i < 3; i++) begin
                r3_ut[i] <= 64'(n_t[i]);
                r3_ud[i] <= 64'(n_den[i]);
            end
        end
    end

    // Stages 4 and 5: scale the ratio terms down until the divisor fits 32 bits.
    logic [127:0]  r4_td [3];
    logic [127:0]  r5_td [3];
    logic [2:0]    r4_ok, r5_ok;
    logic [63:0]   r4_dab, r4_dbc, r5_dab, r5_dbc;
    tps_pkg::t_tri r4_vtx, r5_vtx;
    logic r_v4, r_v5;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r4_td[i] <= norm_step(norm_step(norm_step({r3_ut[i], r3_ud[i]}, 32), 16), 8);
                r5_td[i] <= norm_step(norm_step(norm_step(r4_td[i], 4), 2), 1);
            end
            r4_vtx <= r3_vtx;
            r4_ok  <= r3_ok;
            r4_dab <= r3_dab;
            r4_dbc <= r3_dbc;
            r5_vtx <= r4_vtx;
            r5_ok  <= r4_ok;
            r5_dab <= r4_dab;
            r5_dbc <= r4_dbc;
        end
    end

    // Crossing ratios.
    logic [2:0] w_vdiv;
    logic [tps_pkg::DIV_STAGES-1:0] w_q [3];
    t_side_div w_sd_in, w_sd;

    for (genvar i = 0; i < 3; i++) begin : g_div
        tps_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (r_v5),
            .i_num   (r5_td[i][95:64]),
            .i_den   (r5_td[i][31:0]),
            .o_valid (w_vdiv[i]),
            .o_quot  (w_q[i])
        );
    end

    assign w_sd_in = '{vtx: r5_vtx, ok: r5_ok, dab: r5_dab, dbc: r5_dbc};

    tps_delay #(.WIDTH($bits(t_side_div)), .DEPTH(tps_pkg::DIV_STAGES)) u_dly_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (w_sd_in),
        .o_q   (w_sd)
    );

    // Stage 6: edge vector times ratio.
    logic signed [63:0] n_hp [3][3];
    logic signed [63:0] r6_hp [3][3];
    tps_pkg::t_tri r6_vtx;
    logic [2:0]    r6_ok;
    logic [63:0]   r6_dab, r6_dbc;
    logic r_v6;

    always_comb begin
        int k;
        for (int i = 0; i < 3; i++) begin
            k = (i == 2) ? 0 : i + 1;
            for (int j = 0; j < 3; j++) begin
                n_hp[i][j] = ($signed({w_sd.vtx[k][j][31], w_sd.vtx[k][j]})
                            - $signed({w_sd.vtx[i][j][31], w_sd.vtx[i][j]}))
                           * $signed({1'b0, w_q[i]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_hp  <= n_hp;
            r6_vtx <= w_sd.vtx;
            r6_ok  <= w_sd.ok;
            r6_dab <= w_sd.dab;
            r6_dbc <= w_sd.dbc;
        end
    end

    // Stage 7: hit points.
    tps_pkg::t_tri n_pt, r7_pt, r7_vtx;
    logic [2:0]    r7_ok;
    logic [63:0]   r7_dab, r7_dbc;
    logic r_v7;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_pt[i][j] = r6_vtx[i][j] + 32'(r6_hp[i][j] >>> tps_pkg::RATIO_BITS);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_pt  <= n_pt;
            r7_vtx <= r6_vtx;
            r7_ok  <= r6_ok;
            r7_dab <= r6_dab;
            r7_dbc <= r6_dbc;
        end
    end

    // Stage 8: gather the hits in edge order.
    tps_pkg::t_vec n_ha, n_hb, r8_ha, r8_hb, r8_hc;
    logic [1:0]    r8_cnt;
    logic          r8_same;
    tps_pkg::t_tri r8_vtx;
    logic [63:0]   r8_dab, r8_dbc;
    logic r_v8;

    assign n_ha = r7_ok[0] ? r7_pt[0] : r7_pt[1];
    assign n_hb = (r7_ok[0] && r7_ok[1]) ? r7_pt[1] : r7_pt[2];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_ha   <= n_ha;
            r8_hb   <= n_hb;
            r8_hc   <= r7_pt[2];
            r8_cnt  <= {1'b0, r7_ok[0]} + {1'b0, r7_ok[1]} + {1'b0, r7_ok[2]};
            r8_same <= same_point(n_ha, n_hb, r_tol);
            r8_vtx  <= r7_vtx;
            r8_dab  <= r7_dab;
            r8_dbc  <= r7_dbc;
        end
    end

    // Stage 9: pick the segment and form the orientation vectors.
    tps_pkg::t_vec n_p1, r9_p0, r9_p1;
    logic signed [63:0] r9_ab [3];
    logic signed [63:0] r9_bc [3];
    logic signed [63:0] r9_dv [3];
    logic          r9_hit;
    logic [63:0]   r9_dab, r9_dbc;
    logic r_v9;

    assign n_p1 = (r8_cnt == 2'd3 && r8_same) ? r8_hc : r8_hb;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_p0  <= r8_ha;
            r9_p1  <= n_p1;
            r9_hit <= (r8_cnt >= 2'd2) && !(r8_cnt == 2'd2 && r8_same);
            r9_dab <= r8_dab;
            r9_dbc <= r8_dbc;
            for (int j = 0; j < 3; j++) begin
                r9_ab[j] <= 64'($signed(r8_vtx[1][j])) - 64'($signed(r8_vtx[0][j]));
                r9_bc[j] <= 64'($signed(r8_vtx[2][j])) - 64'($signed(r8_vtx[1][j]));
                r9_dv[j] <= 64'($signed(n_p1[j])) - 64'($signed(r8_ha[j]));
            end
        end
    end

    // Dot products of both edges with the segment direction.
    logic [5:0] w_vm1;
    logic signed [127:0] w_pab [3];
    logic signed [127:0] w_pbc [3];
    t_side_dot w_sdot_in, w_sdot;

    for (genvar j = 0; j < 3; j++) begin : g_dot
        tps_mul u_mul_ab (
            .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en), .i_valid (r_v9),
            .i_a (r9_ab[j]), .i_b (r9_dv[j]), .o_valid (w_vm1[j]), .o_p (w_pab[j])
        );
        tps_mul u_mul_bc (
            .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en), .i_valid (r_v9),
            .i_a (r9_bc[j]), .i_b (r9_dv[j]), .o_valid (w_vm1[3+j]), .o_p (w_pbc[j])
        );
    end

    assign w_sdot_in = '{p0: r9_p0, p1: r9_p1, hit: r9_hit, dab: r9_dab, dbc: r9_dbc};

    tps_delay #(.WIDTH($bits(t_side_dot)), .DEPTH(tps_pkg::MUL_STAGES)) u_dly_dot (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (w_sdot_in),
        .o_q   (w_sdot)
    );

    // Stage 10: scaled dot sums.
    logic signed [127:0] n_sab, n_sbc;
    logic signed [63:0]  r10_dab_dot, r10_dbc_dot;
    logic signed [63:0]  r10_dab, r10_dbc;
    tps_pkg::t_vec       r10_p0, r10_p1;
    logic                r10_hit;
    logic r_v10;

    assign n_sab = w_pab[0] + w_pab[1] + w_pab[2];
    assign n_sbc = w_pbc[0] + w_pbc[1] + w_pbc[2];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r10_dab_dot <= 64'(n_sab >>> COORD_FRAC_BITS);
            r10_dbc_dot <= 64'(n_sbc >>> COORD_FRAC_BITS);
            r10_dab     <= w_sdot.dab;
            r10_dbc     <= w_sdot.dbc;
            r10_p0      <= w_sdot.p0;
            r10_p1      <= w_sdot.p1;
            r10_hit     <= w_sdot.hit;
        end
    end

    // Orientation products.
    logic [1:0] w_vm2;
    logic signed [127:0] w_w1, w_w2;
    t_side_fin w_sfin_in, w_sfin;

    tps_mul u_mul_w1 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en), .i_valid (r_v10),
        .i_a (r10_dab_dot), .i_b (r10_dbc), .o_valid (w_vm2[0]), .o_p (w_w1)
    );
    tps_mul u_mul_w2 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en), .i_valid (r_v10),
        .i_a (r10_dbc_dot), .i_b (r10_dab), .o_valid (w_vm2[1]), .o_p (w_w2)
    );

    assign w_sfin_in = '{p0: r10_p0, p1: r10_p1, hit: r10_hit};

    tps_delay #(.WIDTH($bits(t_side_fin)), .DEPTH(tps_pkg::MUL_STAGES)) u_dly_fin (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (w_sfin_in),
        .o_q   (w_sfin)
    );

    // Output register.
    logic          w_pos;
    tps_pkg::t_vec r_out_s, r_out_e;
    logic          r_out_hit;

    assign w_pos = w_w1 > w_w2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_hit <= w_sfin.hit;
            if (!w_sfin.hit) begin
                r_out_s <= '0;
                r_out_e <= '0;
            end else begin
                r_out_s <= w_pos ? w_sfin.p0 : w_sfin.p1;
                r_out_e <= w_pos ? w_sfin.p1 : w_sfin.p0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_v6        <= 1'b0;
            r_v7        <= 1'b0;
            r_v8        <= 1'b0;
            r_v9        <= 1'b0;
            r_v10       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_v1        <= w_acc;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            r_v5        <= r_v4;
            r_v6        <= &w_vdiv;
            r_v7        <= r_v6;
            r_v8        <= r_v7;
            r_v9        <= r_v8;
            r_v10       <= &w_vm1;
            r_out_valid <= &w_vm2;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_hit     = r_out_hit;
    assign o_start_x = r_out_s[0];
    assign o_start_y = r_out_s[1];
    assign o_start_z = r_out_s[2];
    assign o_end_x   = r_out_e[0];
    assign o_end_y   = r_out_e[1];
    assign o_end_z   = r_out_e[2];

`ifndef SYNTHESIS
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (r_out_s == '0 && r_out_e == '0))
        else $error("miss word carries nonzero coordinates");

    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vdiv[0] == w_vdiv[1]) && (w_vdiv[1] == w_vdiv[2]))
        else $error("divider lanes out of step");

    a_mul_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vm2[0] == w_vm2[1]) && ((&w_vm1) == (|w_vm1)))
        else $error("multiplier lanes out of step");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");
`endif

endmodule

// File: rtl/core/tps_delay.sv
// ----------------------------------------------------------------------------
// tps_delay
// Enabled shift line that carries side data alongside a pipelined unit.
// ----------------------------------------------------------------------------
module tps_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_q [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= i_d;
            for (int s = 1; s < DEPTH; s++) begin
                r_q[s] <= r_q[s-1];
            end
        end
    end

    assign o_q = r_q[DEPTH-1];

endmodule

// File: rtl/core/tps_mul.sv
// ----------------------------------------------------------------------------
// tps_mul
// Three-stage signed 64 by 64 multiplier built from four 32 by 32 products.
// ----------------------------------------------------------------------------
module tps_mul (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [63:0]   i_a,
    input  logic signed [63:0]   i_b,
    output logic                 o_valid,
    output logic signed [127:0]  o_p
);

    logic         r_v1, r_v2, r_v3;
    logic         r_neg1, r_neg2;
    logic [63:0]  r_ua, r_ub;
    logic [63:0]  r_pp0, r_pp1, r_pp2, r_pp3;
    logic [127:0] n_sum;
    logic signed [127:0] r_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_comb begin
        n_sum = {64'd0, r_pp0} + {32'd0, r_pp1, 32'd0} + {32'd0, r_pp2, 32'd0}
              + {r_pp3, 64'd0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg1 <= i_a[63] ^ i_b[63];
            r_ua   <= i_a[63] ? 64'(-i_a) : 64'(i_a);
            r_ub   <= i_b[63] ? 64'(-i_b) : 64'(i_b);
            r_neg2 <= r_neg1;
            r_pp0  <= r_ua[31:0]  * r_ub[31:0];
            r_pp1  <= r_ua[31:0]  * r_ub[63:32];
            r_pp2  <= r_ua[63:32] * r_ub[31:0];
            r_pp3  <= r_ua[63:32] * r_ub[63:32];
            r_p    <= r_neg2 ? $signed(-n_sum) : $signed(n_sum);
        end
    end

    assign o_valid = r_v3;
    assign o_p     = r_p;

endmodule

// File: rtl/core/tps_div.sv
// ----------------------------------------------------------------------------
// tps_div
// Pipelined restoring divider, one quotient bit per stage, for the crossing
// ratio floor(num * 2^30 / den) with num not above den.
// ----------------------------------------------------------------------------
module tps_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [31:0]                     i_num,
    input  logic [31:0]                     i_den,
    output logic                            o_valid,
    output logic [tps_pkg::DIV_STAGES-1:0]  o_quot
);

    localparam int N = tps_pkg::DIV_STAGES;

    logic         r_valid [N];
    logic [31:0]  r_rem   [N];
    logic [31:0]  r_den   [N];
    logic [N-1:0] r_quot  [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic         w_vin;
        logic [31:0]  w_rem, w_den;
        logic [N-1:0] w_q;
        logic         w_bit;
        logic [32:0]  w_t;
        logic         w_ge;

        if (k == 0) begin : g_first
            assign w_vin = i_valid;
            assign w_rem = {1'b0, i_num[31:1]};
            assign w_bit = i_num[0];
            assign w_den = i_den;
            assign w_q   = '0;
        end else begin : g_next
            assign w_vin = r_valid[k-1];
            assign w_rem = r_rem[k-1];
            assign w_bit = 1'b0;
            assign w_den = r_den[k-1];
            assign w_q   = r_quot[k-1];
        end

        assign w_t  = {w_rem, w_bit};
        assign w_ge = w_t >= {1'b0, w_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? 32'(w_t - {1'b0, w_den}) : w_t[31:0];
                r_den[k]  <= w_den;
                r_quot[k] <= {w_q[N-2:0], w_ge};
            end
        end
    end

    assign o_valid = r_valid[N-1];
    assign o_quot  = r_quot[N-1];

endmodule
